@@ design/pse_pkg.sv @@
package pse_pkg;

	// Fixed field widths of the channels
	localparam int IN_COORD_W = 12;
	localparam int HW_W       = 8;
	localparam int OUT_W      = 22;
	localparam logic [HW_W-1:0] HW_RESET = 8'd10;

	// Defaults of the top-level parameters
	localparam int COORD_BITS_DEF = 12;
	localparam int FRAC_BITS_DEF  = 8;

	// Unit vector precision and the iteration counts that follow from it
	localparam int UNIT_BITS = 16;
	localparam int U_W       = UNIT_BITS + 1;
	localparam int Q_W       = 2 * UNIT_BITS + 1;
	localparam int T_W       = Q_W + 1;
	localparam int DIV_STEPS = 2 * UNIT_BITS;
	localparam int CNT_W     = $clog2(DIV_STEPS);
	localparam int BIT_W     = $clog2(U_W);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SETUP,
		ST_LOAD,
		ST_DIV,
		ST_ROUND,
		ST_SQRT,
		ST_SCALE,
		ST_OUT,
		ST_UPDATE
	} state_t;

	// Which three points feed one vertex pair
	typedef enum logic [1:0] {
		SEL_SINGLE,
		SEL_MID,
		SEL_END
	} sel_t;

	// Window update at the end of an item
	typedef enum logic [1:0] {
		WIN_OPEN,
		WIN_SHIFT,
		WIN_CLOSE
	} win_t;

	typedef struct packed {
		logic             latch_in;
		logic             setup;
		sel_t             sel;
		logic             load_comp;
		logic             comp_sel;
		logic             div_step;
		logic             round;
		logic             sqrt_step;
		logic [BIT_W-1:0] bit_idx;
		logic             scale;
		logic             write_out;
		logic             strip_end;
		logic             tail;
		logic             win_update;
		win_t             win_op;
	} cmd_t;

	typedef struct packed {
		logic line_open;
		logic zero_len;
		logic out_free;
	} status_t;

endpackage

@@ design/pse_if.sv @@
interface pse_pt_if;
	logic                             valid;
	logic                             ready;
	logic [pse_pkg::IN_COORD_W-1:0]   x_pos;
	logic [pse_pkg::IN_COORD_W-1:0]   y_pos;
	logic                             first;
	logic                             last;
	modport source(output valid, x_pos, y_pos, first, last, input ready);
	modport sink(input valid, x_pos, y_pos, first, last, output ready);
endinterface

interface pse_vtx_if;
	logic                             valid;
	logic                             ready;
	logic signed [pse_pkg::OUT_W-1:0] left_x;
	logic signed [pse_pkg::OUT_W-1:0] left_y;
	logic signed [pse_pkg::OUT_W-1:0] right_x;
	logic signed [pse_pkg::OUT_W-1:0] right_y;
	logic                             strip_end;
	logic                             last_of_run;
	modport source(output valid, left_x, left_y, right_x, right_y, strip_end, last_of_run,
		input ready);
	modport sink(input valid, left_x, left_y, right_x, right_y, strip_end, last_of_run,
		output ready);
endinterface

interface pse_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [pse_pkg::HW_W-1:0]   half_width;
	modport source(output valid, half_width, input ready);
	modport sink(input valid, half_width, output ready);
endinterface

@@ design/polyline_stroke_extruder.sv @@
// Polyline stroke extruder: turns polyline points into triangle strip vertex pairs.
// pts: one point per transfer (x_pos, y_pos, first, last); ready is high only
//   while the block is idle, so one point is worked on at a time.
// verts: one vertex pair per transfer, point plus and minus the offset
//   perpendicular to the direction, signed with FRAC_BITS fraction bits.
// cfg: half_width write; take it only between points.
// A point that only opens a line passes the update state and returns to ready.
// For a pair, each offset component goes through one compare, a
// 2*16-step restoring divide, a rounding step, a 17-step bit-by-bit square
// root and a scale, all on one shared divider and root unit; a zero-length
// direction skips them.
// A last point on an open line gives two pairs.
// A pair is held in the output register until taken; a stall there holds the
// controller in its output state and keeps pts ready low.
// Reset closes any open line, drops a pending pair and sets half_width to 10.
module polyline_stroke_extruder #(
	parameter int COORD_BITS = pse_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = pse_pkg::FRAC_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	pse_pt_if.sink     pts,
	pse_vtx_if.source  verts,
	pse_cfg_if.sink    cfg
);
	import pse_pkg::*;

	cmd_t    cmd;
	status_t status;
	logic    in_ready;

	assign pts.ready = in_ready;

	pse_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pts.valid),
		.in_first (pts.first),
		.in_last  (pts.last),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	pse_datapath #(
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.x_pos  (pts.x_pos),
		.y_pos  (pts.y_pos),
		.cfg    (cfg),
		.verts  (verts),
		.cmd    (cmd),
		.status (status)
	);

	// Never overwrite a pair that is still waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write_out |-> status.out_free)
		else $error("result written over a pending pair");

	// No point accepted while the arithmetic runs
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_step || cmd.sqrt_step || cmd.scale) |-> !in_ready)
		else $error("point accepted during computation");

	// The final pair of a line is always the last of its run
	assert property (@(posedge clk) disable iff (!arst_n)
		(verts.valid && verts.strip_end) |-> verts.last_of_run)
		else $error("strip end without end of run");

	// A written pair is offered in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write_out |=> verts.valid)
		else $error("written pair not offered");

endmodule

@@ design/pse_ctrl.sv @@
module pse_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_first,
	input  logic             in_last,
	output logic             in_ready,
	input  pse_pkg::status_t status,
	output pse_pkg::cmd_t    cmd
);
	import pse_pkg::*;

	state_t           state_q, state_nxt;
	logic [CNT_W-1:0] cnt_q;
	logic             comp_q;
	sel_t             sel_q;
	logic             end_q;
	logic             se_q;
	logic             tail_q;
	win_t             win_q;
	logic             accept;
	logic             line_open;

	assign accept    = (state_q == ST_IDLE) && in_valid;
	assign line_open = !in_first && status.line_open;

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_nxt = (line_open || in_last) ? ST_SETUP : ST_UPDATE;
				end
			end
			ST_SETUP:  state_nxt = ST_LOAD;
			ST_LOAD:   state_nxt = status.zero_len ? ST_OUT : ST_DIV;
			ST_DIV: begin
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					state_nxt = ST_ROUND;
				end
			end
			ST_ROUND:  state_nxt = ST_SQRT;
			ST_SQRT: begin
				if (cnt_q == CNT_W'(UNIT_BITS)) begin
					state_nxt = ST_SCALE;
				end
			end
			ST_SCALE:  state_nxt = comp_q ? ST_OUT : ST_LOAD;
			ST_OUT: begin
				if (status.out_free) begin
					state_nxt = end_q ? ST_SETUP : ST_UPDATE;
				end
			end
			ST_UPDATE: state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	// Commands to the datapath
	always_comb begin
		cmd            = '0;
		cmd.sel        = sel_q;
		cmd.win_op     = win_q;
		cmd.comp_sel   = comp_q;
		cmd.strip_end  = se_q;
		cmd.tail       = tail_q;
		cmd.bit_idx    = BIT_W'(UNIT_BITS) - BIT_W'(cnt_q);
		cmd.latch_in   = accept;
		cmd.setup      = (state_q == ST_SETUP);
		cmd.load_comp  = (state_q == ST_LOAD);
		cmd.div_step   = (state_q == ST_DIV);
		cmd.round      = (state_q == ST_ROUND);
		cmd.sqrt_step  = (state_q == ST_SQRT);
		cmd.scale      = (state_q == ST_SCALE);
		cmd.write_out  = (state_q == ST_OUT) && status.out_free;
		cmd.win_update = (state_q == ST_UPDATE);
	end

	assign in_ready = (state_q == ST_IDLE);

	// Hold the plan for the item and count iterations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			comp_q  <= 1'b0;
			sel_q   <= SEL_SINGLE;
			end_q   <= 1'b0;
			se_q    <= 1'b0;
			tail_q  <= 1'b0;
			win_q   <= WIN_OPEN;
		end else begin
			state_q <= state_nxt;
			if (accept) begin
				if (line_open) begin
					sel_q  <= SEL_MID;
					se_q   <= 1'b0;
					tail_q <= !in_last;
					end_q  <= in_last;
					win_q  <= in_last ? WIN_CLOSE : WIN_SHIFT;
				end else begin
					sel_q  <= SEL_SINGLE;
					se_q   <= 1'b1;
					tail_q <= 1'b1;
					end_q  <= 1'b0;
					win_q  <= in_last ? WIN_CLOSE : WIN_OPEN;
				end
			end
			if (state_q == ST_SETUP) begin
				comp_q <= 1'b0;
			end
			if (state_q == ST_SCALE) begin
				comp_q <= 1'b1;
			end
			if (state_q == ST_LOAD || state_q == ST_ROUND) begin
				cnt_q <= '0;
			end else if (state_q == ST_DIV || state_q == ST_SQRT) begin
				cnt_q <= cnt_q + 1'b1;
			end
			// Queue the final point's pair after the held point's pair
			if (state_q == ST_OUT && status.out_free && end_q) begin
				sel_q  <= SEL_END;
				se_q   <= 1'b1;
				tail_q <= 1'b1;
				end_q  <= 1'b0;
			end
		end
	end

endmodule

@@ design/pse_datapath.sv @@
module pse_datapath #(
	parameter int COORD_BITS = pse_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = pse_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [pse_pkg::IN_COORD_W-1:0] x_pos,
	input  logic [pse_pkg::IN_COORD_W-1:0] y_pos,
	pse_cfg_if.sink                        cfg,
	pse_vtx_if.source                      verts,
	input  pse_pkg::cmd_t                  cmd,
	output pse_pkg::status_t               status
);
	import pse_pkg::*;

	localparam int D_W    = COORD_BITS + 1;
	localparam int SQ_W   = 2 * COORD_BITS;
	localparam int S_W    = SQ_W + 1;
	localparam int R_W    = SQ_W + 2;
	localparam int PROD_W = HW_W + U_W;
	localparam int WIDE_W = PROD_W + UNIT_BITS + 1;
	localparam int SH_R   = (FRAC_BITS < UNIT_BITS) ? UNIT_BITS - FRAC_BITS : 0;
	localparam int SH_L   = (FRAC_BITS > UNIT_BITS) ? FRAC_BITS - UNIT_BITS : 0;
	localparam logic [WIDE_W-1:0] RND =
		(FRAC_BITS < UNIT_BITS) ? (WIDE_W'(1) << (SH_R - 1)) : '0;
	localparam int P_W    = COORD_BITS + FRAC_BITS;

	// Point window and latched input
	logic [COORD_BITS-1:0] prev_x_q, prev_y_q, held_x_q, held_y_q;
	logic [1:0]            pts_q;
	logic [COORD_BITS-1:0] in_x_q, in_y_q;
	logic [HW_W-1:0]       half_width_q;

	// Emit operands
	logic [COORD_BITS-1:0] ax, ay, bx, by, cx, cy;
	logic signed [D_W-1:0] dx, dy;
	logic [COORD_BITS-1:0] adx, ady;
	logic [COORD_BITS-1:0] adx_q, ady_q, bx_q, by_q;
	logic [S_W-1:0]        s_q;
	logic                  dx_neg_q, dy_pos_q;

	// Divider, square root and scaling
	logic [COORD_BITS-1:0] comp;
	logic [SQ_W-1:0]       comp_sq;
	logic [R_W-1:0]        r_q, r2;
	logic [Q_W-1:0]        q_q;
	logic [T_W-1:0]        t_q;
	logic [U_W-1:0]        u_q, c_try;
	logic [2*U_W-1:0]      k_try;
	logic [PROD_W-1:0]     prod;
	logic [WIDE_W-1:0]     mag_wide;
	logic [OUT_W-1:0]      mx_q, my_q, ox, oy, px, py;
	logic                  out_valid_q;

	// Pick the three points of the pair
	always_comb begin
		case (cmd.sel)
			SEL_MID: begin
				ax = prev_x_q; ay = prev_y_q;
				bx = held_x_q; by = held_y_q;
			end
			SEL_END: begin
				ax = held_x_q; ay = held_y_q;
				bx = in_x_q;   by = in_y_q;
			end
			default: begin
				ax = in_x_q;   ay = in_y_q;
				bx = in_x_q;   by = in_y_q;
			end
		endcase
		cx  = in_x_q;
		cy  = in_y_q;
		dx  = $signed({1'b0, cx}) - $signed({1'b0, ax});
		dy  = $signed({1'b0, cy}) - $signed({1'b0, ay});
		adx = dx[D_W-1] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
		ady = dy[D_W-1] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
	end

	assign comp    = cmd.comp_sel ? adx_q : ady_q;
	assign comp_sq = comp * comp;
	assign r2      = {r_q[R_W-2:0], 1'b0};
	assign c_try   = u_q | (U_W'(1) << cmd.bit_idx);
	assign k_try   = c_try * c_try - (2*U_W)'(c_try);
	assign prod    = half_width_q * u_q;
	assign mag_wide = (((WIDE_W'(prod)) + RND) >> SH_R) << SH_L;

	// Offsets take their signs from the direction vector
	assign ox = dy_pos_q ? -mx_q : mx_q;
	assign oy = dx_neg_q ? -my_q : my_q;
	assign px = OUT_W'(P_W'(bx_q) << FRAC_BITS);
	assign py = OUT_W'(P_W'(by_q) << FRAC_BITS);

	assign status.line_open = (pts_q != 2'd0);
	assign status.zero_len  = (s_q == '0);
	assign status.out_free  = !out_valid_q || verts.ready;
	assign cfg.ready        = 1'b1;
	assign verts.valid      = out_valid_q;

	// Configuration and window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_width_q <= HW_RESET;
			pts_q        <= 2'd0;
			prev_x_q     <= '0;
			prev_y_q     <= '0;
			held_x_q     <= '0;
			held_y_q     <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg.valid) begin
				half_width_q <= cfg.half_width;
			end
			if (cmd.win_update) begin
				case (cmd.win_op)
					WIN_OPEN: begin
						prev_x_q <= in_x_q; prev_y_q <= in_y_q;
						held_x_q <= in_x_q; held_y_q <= in_y_q;
						pts_q    <= 2'd1;
					end
					WIN_SHIFT: begin
						prev_x_q <= held_x_q; prev_y_q <= held_y_q;
						held_x_q <= in_x_q;   held_y_q <= in_y_q;
						pts_q    <= 2'd2;
					end
					default: pts_q <= 2'd0;
				endcase
			end
			// Hold the result until the transfer completes
			if (cmd.write_out) begin
				out_valid_q <= 1'b1;
			end else if (verts.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Arithmetic registers
	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			in_x_q <= COORD_BITS'(x_pos);
			in_y_q <= COORD_BITS'(y_pos);
		end
		if (cmd.setup) begin
			adx_q    <= adx;
			ady_q    <= ady;
			s_q      <= S_W'(adx) * S_W'(adx) + S_W'(ady) * S_W'(ady);
			dx_neg_q <= dx[D_W-1];
			dy_pos_q <= !dy[D_W-1] && (dy != '0);
			bx_q     <= bx;
			by_q     <= by;
			mx_q     <= '0;
			my_q     <= '0;
		end
		// Top quotient bit: the squared component never exceeds the sum
		if (cmd.load_comp) begin
			if (S_W'(comp_sq) >= s_q) begin
				r_q <= R_W'(S_W'(comp_sq) - s_q);
				q_q <= Q_W'(1);
			end else begin
				r_q <= R_W'(comp_sq);
				q_q <= '0;
			end
		end
		// One restoring division step
		if (cmd.div_step) begin
			if (r2 >= R_W'(s_q)) begin
				r_q <= r2 - R_W'(s_q);
				q_q <= {q_q[Q_W-2:0], 1'b1};
			end else begin
				r_q <= r2;
				q_q <= {q_q[Q_W-2:0], 1'b0};
			end
		end
		// Round-up threshold from the remainder
		if (cmd.round) begin
			t_q <= T_W'(q_q) + T_W'((({r_q, 2'b00}) >= (R_W+2)'(s_q)) ? 1 : 0);
			u_q <= '0;
		end
		// One root bit per step
		if (cmd.sqrt_step) begin
			if (k_try < t_q) begin
				u_q <= c_try;
			end
		end
		if (cmd.scale) begin
			if (cmd.comp_sel) begin
				my_q <= OUT_W'(mag_wide);
			end else begin
				mx_q <= OUT_W'(mag_wide);
			end
		end
		if (cmd.write_out) begin
			verts.left_x      <= px + ox;
			verts.left_y      <= py + oy;
			verts.right_x     <= px - ox;
			verts.right_y     <= py - oy;
			verts.strip_end   <= cmd.strip_end;
			verts.last_of_run <= cmd.tail;
		end
	end

endmodule
